### rtl/core/vpuf_pkg.sv
// ----------------------------------------------------------------------------
// vpuf_pkg
// Shared types and constants for the video pixel unpack FIFO.
// ----------------------------------------------------------------------------
package vpuf_pkg;

   // Buffer geometry: eight 32-bit words, an 8-bit bit pointer over all of them.
   localparam int FifoDepth    = 8;
   localparam int WordWidth    = 32;
   localparam int WordPosWidth = $clog2(FifoDepth);
   localparam int BitPosWidth  = $clog2(FifoDepth * WordWidth);
   localparam int BitOffWidth  = $clog2(WordWidth);
   localparam int PixelWidth   = 8;

   // Field and register widths.
   localparam int CommandWidth = 2;
   localparam int RequestWidth = 2;
   localparam int BppWidth     = 2;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 2;

   // Bit offsets within a word that raise a DMA request.
   localparam logic [BitOffWidth-1:0] DmaOffsetLate = 5'd28;
   localparam logic [BitOffWidth-1:0] DmaOffset8bpp = 5'd24;

   // Input commands.
   typedef enum logic [CommandWidth-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   // Pixel size codes (log2 of bits per pixel).
   typedef enum logic [BppWidth-1:0] {
      BPP_1 = 2'd0,
      BPP_2 = 2'd1,
      BPP_4 = 2'd2,
      BPP_8 = 2'd3
   } bpp_type;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CsrBppCode     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrDmaReqWord  = 2'd1;

   // DMA request counts.
   localparam logic [RequestWidth-1:0] ReqNone  = 2'd0;
   localparam logic [RequestWidth-1:0] ReqOne   = 2'd1;
   localparam logic [RequestWidth-1:0] ReqTwo   = 2'd2;

   // Result of one pixel extraction.
   typedef struct packed {
      logic [PixelWidth-1:0] pixel;
      logic                  request;
   } extract_type;

endpackage

### rtl/core/video_pixel_unpack_fifo.sv
// ----------------------------------------------------------------------------
// video_pixel_unpack_fifo
// Eight-word video buffer that is filled a word at a time and read out one
// 1, 2, 4 or 8 bit pixel at a time, with DMA request generation.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries a command and a data word. Each transfer produces
//   exactly one transfer on the rsp channel with the pixel (zero unless the
//   command is a read) and the number of DMA request pulses (0, 1 or 2).
//   An accepted item is held in the input register and is then processed
//   into the output register, which drives rsp_valid. One item per cycle is
//   sustained while rsp_stall is low; the limit is the single read port on
//   the word buffer plus the bit pointer update.
//   The input register lets one item be accepted while a result waits on a
//   stalled receiver; req_stall rises only when both registers are full.
//   Reset clears the stored words, both pointers, the pixel size (1 bpp) and
//   sets the DMA request slot to 3. The csr port must be written only while
//   idle, not enforced here; a pixel size write also clears both pointers.
// ----------------------------------------------------------------------------
module video_pixel_unpack_fifo (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [vpuf_pkg::CommandWidth-1:0]   req_command,
   input  logic [vpuf_pkg::WordWidth-1:0]      req_data_word,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [vpuf_pkg::PixelWidth-1:0]     rsp_pixel,
   output logic [vpuf_pkg::RequestWidth-1:0]   rsp_dma_requests,
   // Configuration write port.
   input  logic                                csr_write_enable,
   input  logic [vpuf_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [vpuf_pkg::CsrDataWidth-1:0]   csr_write_data
);

   // Input register.
   logic                                 s1_valid_ff, s1_valid_in;
   vpuf_pkg::command_type                s1_command_ff;
   logic [vpuf_pkg::WordWidth-1:0]       s1_data_ff;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [vpuf_pkg::PixelWidth-1:0]      rsp_pixel_ff, rsp_pixel_in;
   logic [vpuf_pkg::RequestWidth-1:0]    rsp_dma_ff, rsp_dma_in;

   // Buffer state and configuration.
   logic [vpuf_pkg::WordWidth-1:0]       fifo_ff [vpuf_pkg::FifoDepth];
   logic [vpuf_pkg::BitPosWidth-1:0]     read_pos_ff, read_pos_in;
   logic [vpuf_pkg::WordPosWidth-1:0]    write_pos_ff, write_pos_in;
   vpuf_pkg::bpp_type                    bpp_ff;
   logic [1:0]                           dma_word_ff;

   logic                                 req_accept;
   logic                                 s1_move;
   logic                                 bpp_write;
   logic [vpuf_pkg::BitPosWidth-1:0]     pixel_step;
   vpuf_pkg::extract_type                extract;

   // Handshake: the input register moves when the output register is free.
   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;
   assign bpp_write  = csr_write_enable && (csr_index == vpuf_pkg::CsrBppCode);

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   // Pixel extraction from the word under the read pointer.
   vpuf_pixel_extract u_extract (
      .word     (fifo_ff[read_pos_ff[vpuf_pkg::BitPosWidth-1:vpuf_pkg::BitOffWidth]]),
      .read_pos (read_pos_ff),
      .bpp      (bpp_ff),
      .dma_word (dma_word_ff),
      .result   (extract)
   );

   // Bits consumed by one read.
   assign pixel_step = vpuf_pkg::BitPosWidth'(1) << bpp_ff;

   // Command decode: result fields and pointer updates.
   always_comb begin
      rsp_pixel_in = '0;
      rsp_dma_in   = vpuf_pkg::ReqNone;
      read_pos_in  = read_pos_ff;
      write_pos_in = write_pos_ff;
      case (s1_command_ff)
         vpuf_pkg::CMD_WRITE: begin
            write_pos_in = write_pos_ff + 1'b1;
         end
         vpuf_pkg::CMD_READ: begin
            rsp_pixel_in = extract.pixel;
            rsp_dma_in   = extract.request ? vpuf_pkg::ReqOne : vpuf_pkg::ReqNone;
            read_pos_in  = read_pos_ff + pixel_step;
         end
         vpuf_pkg::CMD_CLEAR: begin
            rsp_dma_in   = vpuf_pkg::ReqTwo;
            read_pos_in  = '0;
            write_pos_in = '0;
         end
         default: begin
            rsp_dma_in   = vpuf_pkg::ReqNone;
         end
      endcase
   end

   // Control state, pointers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         read_pos_ff  <= '0;
         write_pos_ff <= '0;
         bpp_ff       <= vpuf_pkg::BPP_1;
         dma_word_ff  <= 2'd3;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (bpp_write) begin
            read_pos_ff  <= '0;
            write_pos_ff <= '0;
            bpp_ff       <= vpuf_pkg::bpp_type'(csr_write_data);
         end else if (s1_move) begin
            read_pos_ff  <= read_pos_in;
            write_pos_ff <= write_pos_in;
         end
         if (csr_write_enable && (csr_index == vpuf_pkg::CsrDmaReqWord)) begin
            dma_word_ff <= csr_write_data;
         end
      end
   end

   // Word buffer: cleared by reset, written on a write command.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < vpuf_pkg::FifoDepth; i++) begin
            fifo_ff[i] <= '0;
         end
      end else if (s1_move && (s1_command_ff == vpuf_pkg::CMD_WRITE)) begin
         fifo_ff[write_pos_ff] <= s1_data_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= vpuf_pkg::command_type'(req_command);
         s1_data_ff    <= req_data_word;
      end
      if (s1_move) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_dma_ff   <= rsp_dma_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel        = rsp_pixel_ff;
   assign rsp_dma_requests = rsp_dma_ff;

endmodule

### rtl/core/vpuf_pixel_extract.sv
// ----------------------------------------------------------------------------
// vpuf_pixel_extract
// Picks the next pixel out of the addressed word and flags a DMA request.
// ----------------------------------------------------------------------------
module vpuf_pixel_extract (
   input  logic [vpuf_pkg::WordWidth-1:0]   word,
   input  logic [vpuf_pkg::BitPosWidth-1:0] read_pos,
   input  vpuf_pkg::bpp_type                bpp,
   input  logic [1:0]                       dma_word,
   output vpuf_pkg::extract_type            result
);

   logic [vpuf_pkg::BitOffWidth-1:0] bit_off;
   logic [vpuf_pkg::WordWidth-1:0]   shifted;
   logic [vpuf_pkg::PixelWidth-1:0]  mask;
   logic                             offset_hit;

   assign bit_off = read_pos[vpuf_pkg::BitOffWidth-1:0];
   assign shifted = word >> bit_off;

   // Pixel mask from the pixel size.
   always_comb begin
      case (bpp)
         vpuf_pkg::BPP_1: mask = 8'h01;
         vpuf_pkg::BPP_2: mask = 8'h03;
         vpuf_pkg::BPP_4: mask = 8'h0F;
         vpuf_pkg::BPP_8: mask = 8'hFF;
         default:         mask = 8'h00;
      endcase
   end

   // A request fires on the late part of the selected word slot.
   assign offset_hit = (bit_off == vpuf_pkg::DmaOffsetLate) ||
                       ((bpp == vpuf_pkg::BPP_8) && (bit_off == vpuf_pkg::DmaOffset8bpp));

   assign result.pixel   = shifted[vpuf_pkg::PixelWidth-1:0] & mask;
   assign result.request = offset_hit &&
                           (read_pos[vpuf_pkg::BitOffWidth+1:vpuf_pkg::BitOffWidth] == dma_word);

endmodule

### rtl/core/vpuf_checker.sv
// ----------------------------------------------------------------------------
// vpuf_checker
// Port-level checks for the video pixel unpack FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module vpuf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [vpuf_pkg::PixelWidth-1:0]    rsp_pixel,
   input logic [vpuf_pkg::RequestWidth-1:0]  rsp_dma_requests
);

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // With no result pending the block always takes a command.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> !req_stall)
      else $error("req_stall high with empty output");

   // A pointer clear gives two requests and never a pixel; three is never reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dma_requests != 2'd3) &&
                    ((rsp_dma_requests != vpuf_pkg::ReqTwo) || (rsp_pixel == '0)))
      else $error("bad DMA request count or pixel on clear");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_dma_requests))
      else $error("stalled result changed");

endmodule

bind video_pixel_unpack_fifo vpuf_checker u_vpuf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_pixel        (rsp_pixel),
   .rsp_dma_requests (rsp_dma_requests)
);
